// File: design/bip_pkg.sv
// Package for the beacon element parser: sizes, field codes and result codes.
// It also holds the command and status structs that pass between the controller and the datapath.
// It depends on nothing.
package bip_pkg;
   localparam int MAX_ENTRIES     = 256;
   localparam int IDX_W           = $clog2(MAX_ENTRIES);
   localparam int CNT_W           = $clog2(MAX_ENTRIES + 1);
   localparam int MAX_FRAME_BYTES = 4096;
   localparam int POS_W           = 13;

   localparam logic [POS_W-1:0] TAG_START = POS_W'(36);
   localparam logic [POS_W-1:0] MIN_FRAME = POS_W'(38);
   localparam logic [POS_W-1:0] BSSID_AT  = POS_W'(16);
   localparam logic [POS_W-1:0] BSSID_END = POS_W'(22);
   localparam logic [POS_W-1:0] FRAME_LIM = POS_W'(MAX_FRAME_BYTES);
   localparam logic [POS_W-1:0] POS_SAT   = '1;

   localparam logic [7:0] PROBE_RESP = 8'h50;
   localparam logic [7:0] SSID_CAP   = 8'd250;
   localparam logic [7:0] PRINT_LO   = 8'd32;
   localparam logic [7:0] PRINT_HI   = 8'd127;
   localparam logic [7:0] TAG_DS     = 8'd3;
   localparam logic [7:0] TAG_SSID   = 8'd0;

   localparam logic [1:0] PH_NONE = 2'd0;
   localparam logic [1:0] PH_HDR  = 2'd1;
   localparam logic [1:0] PH_LEN  = 2'd2;

   localparam logic [2:0] ST_NEW       = 3'd0;
   localparam logic [2:0] ST_KNOWN     = 3'd1;
   localparam logic [2:0] ST_MALFORMED = 3'd2;
   localparam logic [2:0] ST_UNPRINT   = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic       take;
      logic       clear_frame;
      logic       clear_idx;
      logic       inc_idx;
      logic       rd;
      logic       update;
      logic       fill;
      logic       load_rsp;
      logic [2:0] status;
   } cmd_type;

   typedef struct packed {
      logic frame_ok;
      logic idx_end;
      logic match;
      logic full;
      logic printable;
   } stat_type;
endpackage

// File: design/beacon_ie_parser_with_bssid_table.sv
// Frame bytes are taken one per cycle with no stall while a frame streams in. After the byte
// marked end of frame, the block stalls the input and checks the frame. It then searches the
// access point table one entry at a time, reading it in S_SRCH and comparing it in S_CMP,
// through one read port of the table RAMs. One status transaction comes out per frame. It
// sits in an output register, so the next frame's bytes are taken while that status waits.
// Top level: it joins bip_controller and bip_datapath and depends on bip_pkg.
module beacon_ie_parser_with_bssid_table (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_frame_byte,
   input  logic       req_end_of_frame,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_entry_index,
   output logic [7:0] rsp_channel,
   output logic       rsp_answered,
   output logic [7:0] rsp_ssid_length
);
   bip_pkg::cmd_type  cmd;
   bip_pkg::stat_type stat;

   bip_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_end_of_frame(req_end_of_frame), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .stat(stat), .cmd(cmd));

   bip_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_frame_byte(req_frame_byte), .rsp_status(rsp_status),
      .rsp_entry_index(rsp_entry_index), .rsp_channel(rsp_channel),
      .rsp_answered(rsp_answered), .rsp_ssid_length(rsp_ssid_length));

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= bip_pkg::ST_FULL)
      else $error("status code out of range");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bip_pkg::ST_MALFORMED || rsp_status == bip_pkg::ST_UNPRINT
      || rsp_status == bip_pkg::ST_FULL) |->
      rsp_entry_index == 8'd0 && rsp_channel == 8'd0 && !rsp_answered
      && rsp_ssid_length == 8'd0)
      else $error("rejected frame carries nonzero fields");

   a_eof_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_end_of_frame |=> req_stall)
      else $error("input not held after end of frame");
endmodule

// File: design/bip_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// It depends on nothing.
module bip_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// File: design/bip_datapath.sv
// Datapath: the element parser registers, the access point table and the result registers.
// It depends on bip_pkg and bip_ram.
module bip_datapath (
   input  logic              clock,
   input  logic              reset,
   input  bip_pkg::cmd_type  cmd,
   output bip_pkg::stat_type stat,
   input  logic [7:0]        req_frame_byte,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_entry_index,
   output logic [7:0]        rsp_channel,
   output logic              rsp_answered,
   output logic [7:0]        rsp_ssid_length
);
   localparam int PW = bip_pkg::POS_W;
   localparam int IW = bip_pkg::IDX_W;
   localparam int CW = bip_pkg::CNT_W;

   logic [PW-1:0] pos_ff, pos_in, ntp_ff, ntp_in;
   logic          over_ff, over_in;
   logic [7:0]    first_ff, first_in;
   logic [47:0]   bssid_ff, bssid_in;
   logic [1:0]    cph_ff, cph_in, sph_ff, sph_in;
   logic [PW-1:0] cst_ff, cst_in, sst_ff, sst_in;
   logic [7:0]    clen_ff, clen_in, slen_ff, slen_in, sgot_ff, sgot_in;
   logic          cgot_ff, cgot_in;
   logic [7:0]    cdat_ff, cdat_in;
   logic          print_ff, print_in;

   logic [CW-1:0] used_ff, used_in, idx_ff, idx_in;
   logic [2:0]    st_ff, st_in;
   logic [7:0]    ri_ff, ri_in, rc_ff, rc_in, rl_ff, rl_in;
   logic          ra_ff, ra_in;

   logic [47:0] bssid_rd;
   logic [7:0]  chan_rd, slen_rd, new_chan, b;
   logic        ans_rd;
   logic [PW:0] p1, ntp1, nxt;
   logic [PW-1:0] off;
   logic          probe, wr_chan;
   logic [IW-1:0] wr_addr;

   assign b     = req_frame_byte;
   assign probe = first_ff == bip_pkg::PROBE_RESP;
   assign p1    = {1'b0, pos_ff};
   assign ntp1  = {1'b0, ntp_ff} + (PW+1)'(1);
   assign nxt   = {1'b0, ntp_ff} + (PW+1)'(2) + (PW+1)'(b);
   assign off   = pos_ff - sst_ff;

   always_comb begin
      pos_in = pos_ff; ntp_in = ntp_ff; over_in = over_ff; first_in = first_ff;
      bssid_in = bssid_ff; cph_in = cph_ff; sph_in = sph_ff; cst_in = cst_ff;
      sst_in = sst_ff; clen_in = clen_ff; slen_in = slen_ff; sgot_in = sgot_ff;
      cgot_in = cgot_ff; cdat_in = cdat_ff; print_in = print_ff;
      if (cmd.clear_frame) begin
         pos_in = '0; ntp_in = bip_pkg::TAG_START; over_in = 1'b0; first_in = '0;
         bssid_in = '0; cph_in = bip_pkg::PH_NONE; sph_in = bip_pkg::PH_NONE;
         cst_in = '0; sst_in = '0; clen_in = '0; slen_in = '0; sgot_in = '0;
         cgot_in = 1'b0; cdat_in = '0; print_in = 1'b1;
      end else if (cmd.take) begin
         if (pos_ff < bip_pkg::FRAME_LIM) begin
            pos_in = pos_ff + PW'(1);
            if (pos_ff == '0) begin
               first_in = b;
            end
            if (pos_ff >= bip_pkg::BSSID_AT && pos_ff < bip_pkg::BSSID_END) begin
               bssid_in = {bssid_ff[39:0], b};
            end
            if (pos_ff == ntp_ff) begin
               if (b == bip_pkg::TAG_DS && cph_ff == bip_pkg::PH_NONE) begin
                  cph_in = bip_pkg::PH_HDR;
               end
               if (b == bip_pkg::TAG_SSID && sph_ff == bip_pkg::PH_NONE) begin
                  sph_in = bip_pkg::PH_HDR;
               end
            end else if (p1 == ntp1) begin
               if (cph_ff == bip_pkg::PH_HDR) begin
                  cph_in  = bip_pkg::PH_LEN;
                  clen_in = b;
                  cst_in  = pos_ff + PW'(1);
               end
               if (sph_ff == bip_pkg::PH_HDR) begin
                  sph_in  = bip_pkg::PH_LEN;
                  slen_in = (b > bip_pkg::SSID_CAP) ? bip_pkg::SSID_CAP : b;
                  sst_in  = pos_ff + PW'(1);
               end
               ntp_in = (nxt > {1'b0, bip_pkg::POS_SAT}) ? bip_pkg::POS_SAT : nxt[PW-1:0];
            end else begin
               if (cph_ff == bip_pkg::PH_LEN && pos_ff == cst_ff && !cgot_ff) begin
                  cdat_in = b;
                  cgot_in = 1'b1;
               end
               if (sph_ff == bip_pkg::PH_LEN && pos_ff >= sst_ff
                   && off < PW'(slen_ff)) begin
                  if (b < bip_pkg::PRINT_LO || b > bip_pkg::PRINT_HI) begin
                     print_in = 1'b0;
                  end
                  sgot_in = sgot_ff + 8'd1;
               end
            end
         end else begin
            over_in = 1'b1;
         end
      end
   end

   assign new_chan = (chan_rd == '0) ? cdat_ff : chan_rd;
   assign wr_chan  = cmd.update || cmd.fill;
   assign wr_addr  = cmd.fill ? used_ff[IW-1:0] : idx_ff[IW-1:0];

   always_comb begin
      used_in = used_ff; idx_in = idx_ff;
      st_in = st_ff; ri_in = ri_ff; rc_in = rc_ff; ra_in = ra_ff; rl_in = rl_ff;
      if (cmd.clear_idx) begin
         idx_in = '0;
      end else if (cmd.inc_idx) begin
         idx_in = idx_ff + CW'(1);
      end
      if (cmd.fill) begin
         used_in = used_ff + CW'(1);
      end
      if (cmd.load_rsp) begin
         st_in = cmd.status;
         ri_in = '0; rc_in = '0; ra_in = 1'b0; rl_in = '0;
         if (cmd.update) begin
            ri_in = 8'(idx_ff);
            rc_in = new_chan;
            ra_in = ans_rd | probe;
            rl_in = slen_rd;
         end else if (cmd.fill) begin
            ri_in = 8'(used_ff);
            rc_in = cdat_ff;
            ra_in = probe;
            rl_in = slen_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; ntp_ff <= bip_pkg::TAG_START; over_ff <= 1'b0; first_ff <= '0;
         bssid_ff <= '0; cph_ff <= bip_pkg::PH_NONE; sph_ff <= bip_pkg::PH_NONE;
         cst_ff <= '0; sst_ff <= '0; clen_ff <= '0; slen_ff <= '0; sgot_ff <= '0;
         cgot_ff <= 1'b0; cdat_ff <= '0; print_ff <= 1'b1;
         used_ff <= '0; idx_ff <= '0;
      end else begin
         pos_ff <= pos_in; ntp_ff <= ntp_in; over_ff <= over_in; first_ff <= first_in;
         bssid_ff <= bssid_in; cph_ff <= cph_in; sph_ff <= sph_in;
         cst_ff <= cst_in; sst_ff <= sst_in; clen_ff <= clen_in; slen_ff <= slen_in;
         sgot_ff <= sgot_in; cgot_ff <= cgot_in; cdat_ff <= cdat_in; print_ff <= print_in;
         used_ff <= used_in; idx_ff <= idx_in;
      end
      st_ff <= st_in; ri_ff <= ri_in; rc_ff <= rc_in; ra_ff <= ra_in; rl_ff <= rl_in;
   end

   bip_ram #(.WIDTH(48), .DEPTH(bip_pkg::MAX_ENTRIES)) u_bssid_ram (
      .clock(clock), .wr_en(cmd.fill), .wr_addr(wr_addr), .wr_data(bssid_ff),
      .rd_en(cmd.rd), .rd_addr(idx_ff[IW-1:0]), .rd_data(bssid_rd));

   bip_ram #(.WIDTH(8), .DEPTH(bip_pkg::MAX_ENTRIES)) u_chan_ram (
      .clock(clock), .wr_en(wr_chan), .wr_addr(wr_addr),
      .wr_data(cmd.fill ? cdat_ff : new_chan),
      .rd_en(cmd.rd), .rd_addr(idx_ff[IW-1:0]), .rd_data(chan_rd));

   bip_ram #(.WIDTH(1), .DEPTH(bip_pkg::MAX_ENTRIES)) u_ans_ram (
      .clock(clock), .wr_en(wr_chan), .wr_addr(wr_addr),
      .wr_data(cmd.fill ? probe : (ans_rd | probe)),
      .rd_en(cmd.rd), .rd_addr(idx_ff[IW-1:0]), .rd_data(ans_rd));

   bip_ram #(.WIDTH(8), .DEPTH(bip_pkg::MAX_ENTRIES)) u_slen_ram (
      .clock(clock), .wr_en(cmd.fill), .wr_addr(wr_addr), .wr_data(slen_ff),
      .rd_en(cmd.rd), .rd_addr(idx_ff[IW-1:0]), .rd_data(slen_rd));

   assign stat.frame_ok = !over_ff && pos_ff >= bip_pkg::MIN_FRAME
      && cph_ff == bip_pkg::PH_LEN && clen_ff == 8'd1 && cgot_ff
      && sph_ff == bip_pkg::PH_LEN && sgot_ff == slen_ff;
   assign stat.idx_end   = idx_ff == used_ff;
   assign stat.match     = bssid_rd == bssid_ff;
   assign stat.full      = used_ff == CW'(bip_pkg::MAX_ENTRIES);
   assign stat.printable = print_ff;

   assign rsp_status      = st_ff;
   assign rsp_entry_index = ri_ff;
   assign rsp_channel     = rc_ff;
   assign rsp_answered    = ra_ff;
   assign rsp_ssid_length = rl_ff;
endmodule

// File: design/bip_controller.sv
// Controller: frame intake, table search sequencing and result handshake.
// It depends on bip_pkg.
module bip_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_end_of_frame,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  bip_pkg::stat_type stat,
   output bip_pkg::cmd_type  cmd
);
   typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SRCH, S_CMP} state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in, free;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = valid_ff;
   assign free      = !valid_ff || !rsp_stall;

   always_comb begin
      cmd      = '0;
      cmd.status = bip_pkg::ST_MALFORMED;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.take = req_valid;
            if (req_valid && req_end_of_frame) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (free) begin
               if (!stat.frame_ok) begin
                  cmd.load_rsp    = 1'b1;
                  cmd.clear_frame = 1'b1;
                  state_in        = S_IDLE;
               end else begin
                  cmd.clear_idx = 1'b1;
                  state_in      = S_SRCH;
               end
            end
         end
         S_SRCH: begin
            if (stat.idx_end) begin
               cmd.load_rsp    = 1'b1;
               cmd.clear_frame = 1'b1;
               state_in        = S_IDLE;
               if (stat.full) begin
                  cmd.status = bip_pkg::ST_FULL;
               end else if (!stat.printable) begin
                  cmd.status = bip_pkg::ST_UNPRINT;
               end else begin
                  cmd.status = bip_pkg::ST_NEW;
                  cmd.fill   = 1'b1;
               end
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (stat.match) begin
               cmd.update      = 1'b1;
               cmd.load_rsp    = 1'b1;
               cmd.clear_frame = 1'b1;
               cmd.status      = bip_pkg::ST_KNOWN;
               state_in        = S_IDLE;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = S_SRCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_rsp) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end
endmodule
